### hdl/fbpa_pkg.sv
// ----------------------------------------------------------------------------
// fbpa_pkg
// Shared types and constants for the fixed block pool allocator: request and
// result payloads, operation and status codes, register map.
// ----------------------------------------------------------------------------
package fbpa_pkg;

  // Field widths fixed by the interface
  localparam int ADDR_W     = 20;
  localparam int REQ_W      = 13;
  localparam int LOG2_W     = 4;
  localparam int COUNT_W    = 6;
  localparam int REG_POOLS  = 4;
  localparam int APB_ADDR_W = 5;
  localparam int APB_DATA_W = 32;

  // Reset values of the pool registers
  localparam logic [LOG2_W-1:0]  POOL0_LOG2_RST  = 4'd2;
  localparam logic [COUNT_W-1:0] POOL0_COUNT_RST = 6'd32;

  typedef enum logic {
    OP_ALLOC = 1'b0,
    OP_FREE  = 1'b1
  } op_t;

  typedef enum logic [1:0] {
    STATUS_GRANTED   = 2'd0,
    STATUS_NO_BLOCK  = 2'd1,
    STATUS_FREED     = 2'd2,
    STATUS_NOT_FOUND = 2'd3
  } status_t;

  // Register indexes (byte address is 4 * index)
  typedef enum logic [2:0] {
    REG_POOL0_SIZE_LOG2   = 3'd0,
    REG_POOL0_BLOCK_COUNT = 3'd1,
    REG_POOL1_SIZE_LOG2   = 3'd2,
    REG_POOL1_BLOCK_COUNT = 3'd3,
    REG_POOL2_SIZE_LOG2   = 3'd4,
    REG_POOL2_BLOCK_COUNT = 3'd5,
    REG_POOL3_SIZE_LOG2   = 3'd6,
    REG_POOL3_BLOCK_COUNT = 3'd7
  } reg_idx_t;

  typedef struct packed {
    op_t               operation;
    logic [REQ_W-1:0]  request_size;
    logic [ADDR_W-1:0] release_address;
  } fbpa_in_t;

  typedef struct packed {
    status_t           status;
    logic [ADDR_W-1:0] block_address;
  } fbpa_out_t;

  // Pool configuration as seen by the datapath
  typedef struct packed {
    logic [REG_POOLS-1:0][LOG2_W-1:0]  size_log2;
    logic [REG_POOLS-1:0][COUNT_W-1:0] block_count;
  } fbpa_cfg_t;

  // Register contents after reset: pool 0 only, all others empty
  localparam fbpa_cfg_t CFG_RST = '{
    size_log2:   {{((REG_POOLS-1)*LOG2_W){1'b0}}, POOL0_LOG2_RST},
    block_count: {{((REG_POOLS-1)*COUNT_W){1'b0}}, POOL0_COUNT_RST}
  };

endpackage

### hdl/fbpa_core.sv
// ----------------------------------------------------------------------------
// fbpa_core
// Single-pass allocate/free datapath: pool bases, size fit, lowest free block
// search, block-start match, and the next value of the used bits.
// ----------------------------------------------------------------------------
module fbpa_core import fbpa_pkg::*; #(
  parameter int POOLS         = 4,
  parameter int SLOTS         = 32,
  parameter int MAX_SIZE_LOG2 = 12
) (
  input  fbpa_cfg_t                     cfg,
  input  fbpa_in_t                      req,
  input  logic [POOLS-1:0][SLOTS-1:0]   used,
  output logic [POOLS-1:0][SLOTS-1:0]   used_nxt,
  output fbpa_out_t                     result
);

  localparam int SW  = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int CW  = $clog2(SLOTS + 1);
  localparam int LW  = $clog2(MAX_SIZE_LOG2 + 1);
  localparam int PW  = (POOLS > 1) ? $clog2(POOLS) : 1;
  localparam int SZW = (MAX_SIZE_LOG2 + 1 > REQ_W) ? MAX_SIZE_LOG2 + 1 : REQ_W;

  logic [LW-1:0]     eff_log2  [POOLS];
  logic [CW-1:0]     eff_cnt   [POOLS];
  logic [ADDR_W-1:0] base      [POOLS];
  logic [SLOTS-1:0]  free_bits [POOLS];
  logic [SLOTS-1:0]  low_bit   [POOLS];
  logic [SW-1:0]     low_idx   [POOLS];
  logic [ADDR_W-1:0] rel_off   [POOLS];
  logic [ADDR_W-1:0] rel_idx   [POOLS];
  logic [POOLS-1:0]  fits;
  logic [POOLS-1:0]  has_free;
  logic [POOLS-1:0]  hit;
  logic              granted;
  logic [PW-1:0]     sel;
  logic [ADDR_W-1:0] grant_addr;

  // Clamp the pool registers and lay the pools back to back
  always_comb begin
    for (int p = 0; p < POOLS; p++) begin
      if (int'(cfg.size_log2[p]) > MAX_SIZE_LOG2) eff_log2[p] = LW'(MAX_SIZE_LOG2);
      else eff_log2[p] = LW'(cfg.size_log2[p]);
      if (int'(cfg.block_count[p]) > SLOTS) eff_cnt[p] = CW'(SLOTS);
      else eff_cnt[p] = CW'(cfg.block_count[p]);
    end
    base[0] = '0;
    for (int p = 1; p < POOLS; p++) begin
      base[p] = base[p-1] + (ADDR_W'(eff_cnt[p-1]) << eff_log2[p-1]);
    end
  end

  // Per pool: size fit, lowest free block, block-start match
  always_comb begin
    for (int p = 0; p < POOLS; p++) begin
      for (int j = 0; j < SLOTS; j++) begin
        free_bits[p][j] = ~used[p][j] && (j < int'(eff_cnt[p]));
      end
      low_bit[p]  = free_bits[p] & (~free_bits[p] + SLOTS'(1));
      low_idx[p]  = '0;
      for (int j = 0; j < SLOTS; j++) begin
        if (low_bit[p][j]) low_idx[p] = low_idx[p] | SW'(j);
      end
      has_free[p] = |free_bits[p];
      fits[p]     = (SZW'(1) << eff_log2[p]) >= SZW'(req.request_size);

      rel_off[p]  = req.release_address - base[p];
      rel_idx[p]  = rel_off[p] >> eff_log2[p];
      hit[p]      = ((rel_off[p] & ((ADDR_W'(1) << eff_log2[p]) - ADDR_W'(1))) == '0)
                    && (rel_idx[p] < ADDR_W'(eff_cnt[p]));
    end
  end

  // Take the first pool in order that fits and has a free block
  always_comb begin
    granted = 1'b0;
    sel     = '0;
    for (int p = 0; p < POOLS; p++) begin
      if (!granted && fits[p] && has_free[p]) begin
        granted = 1'b1;
        sel     = PW'(p);
      end
    end
    grant_addr = base[sel] + (ADDR_W'(low_idx[sel]) << eff_log2[sel]);
  end

  // Build the result and the next used bits
  always_comb begin
    used_nxt = used;
    result   = '{status: STATUS_NO_BLOCK, block_address: '0};
    if (req.operation == OP_ALLOC) begin
      if (granted) begin
        used_nxt[sel]        = used[sel] | low_bit[sel];
        result.status        = STATUS_GRANTED;
        result.block_address = grant_addr;
      end
    end else begin
      for (int p = 0; p < POOLS; p++) begin
        if (hit[p]) used_nxt[p][rel_idx[p][SW-1:0]] = 1'b0;
      end
      result.status = (|hit) ? STATUS_FREED : STATUS_NOT_FOUND;
    end
  end

endmodule

### hdl/fixed_block_pool_allocator_core.sv
// ----------------------------------------------------------------------------
// fixed_block_pool_allocator_core
// Fixed-size block pool allocator with an APB register port for the pool
// geometry and valid/stall request and result channels.
// ----------------------------------------------------------------------------
// Accepts one allocate or free request per clock and returns one result per
// request, in order. A request is registered on acceptance, evaluated against
// the used bits in a single combinational pass, and its result lands in the
// output register at the next edge unless a stalled result still holds it,
// raising out_valid; the used bits are updated on that same edge, which lets
// the next request follow immediately. Throughput is one request per cycle
// until out_stall backs up. The used bits clear at reset; pool registers
// should only be written while no request is in flight.
module fixed_block_pool_allocator_core import fbpa_pkg::*; #(
  parameter int POOLS         = 4,
  parameter int SLOTS         = 32,
  parameter int MAX_SIZE_LOG2 = 12
) (
  input  logic                  clk,
  input  logic                  rst_n,
  // request channel
  input  logic                  in_valid,
  output logic                  in_stall,
  input  fbpa_in_t              in_data,
  // result channel
  output logic                  out_valid,
  input  logic                  out_stall,
  output fbpa_out_t             out_data,
  // register port
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [APB_DATA_W-1:0] pwdata,
  output logic [APB_DATA_W-1:0] prdata,
  output logic                  pready
);

  fbpa_cfg_t                   cfg_r;
  logic                        s1_valid_r;
  fbpa_in_t                    s1_data_r;
  logic                        out_valid_r;
  fbpa_out_t                   out_data_r;
  logic [POOLS-1:0][SLOTS-1:0] used_r;
  logic [POOLS-1:0][SLOTS-1:0] used_nxt;
  fbpa_out_t                   result;
  logic                        in_acc;
  logic                        adv;
  logic                        cfg_wr;
  reg_idx_t                    reg_idx;

  // Register port
  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite;
  assign reg_idx = reg_idx_t'(paddr[4:2]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= CFG_RST;
    end else if (cfg_wr) begin
      case (reg_idx)
        REG_POOL0_SIZE_LOG2:   cfg_r.size_log2[0]   <= pwdata[LOG2_W-1:0];
        REG_POOL0_BLOCK_COUNT: cfg_r.block_count[0] <= pwdata[COUNT_W-1:0];
        REG_POOL1_SIZE_LOG2:   cfg_r.size_log2[1]   <= pwdata[LOG2_W-1:0];
        REG_POOL1_BLOCK_COUNT: cfg_r.block_count[1] <= pwdata[COUNT_W-1:0];
        REG_POOL2_SIZE_LOG2:   cfg_r.size_log2[2]   <= pwdata[LOG2_W-1:0];
        REG_POOL2_BLOCK_COUNT: cfg_r.block_count[2] <= pwdata[COUNT_W-1:0];
        REG_POOL3_SIZE_LOG2:   cfg_r.size_log2[3]   <= pwdata[LOG2_W-1:0];
        REG_POOL3_BLOCK_COUNT: cfg_r.block_count[3] <= pwdata[COUNT_W-1:0];
        default: ;
      endcase
    end
  end

  // Read back the addressed register
  always_comb begin
    case (reg_idx)
      REG_POOL0_SIZE_LOG2:   prdata = APB_DATA_W'(cfg_r.size_log2[0]);
      REG_POOL0_BLOCK_COUNT: prdata = APB_DATA_W'(cfg_r.block_count[0]);
      REG_POOL1_SIZE_LOG2:   prdata = APB_DATA_W'(cfg_r.size_log2[1]);
      REG_POOL1_BLOCK_COUNT: prdata = APB_DATA_W'(cfg_r.block_count[1]);
      REG_POOL2_SIZE_LOG2:   prdata = APB_DATA_W'(cfg_r.size_log2[2]);
      REG_POOL2_BLOCK_COUNT: prdata = APB_DATA_W'(cfg_r.block_count[2]);
      REG_POOL3_SIZE_LOG2:   prdata = APB_DATA_W'(cfg_r.size_log2[3]);
      REG_POOL3_BLOCK_COUNT: prdata = APB_DATA_W'(cfg_r.block_count[3]);
      default:               prdata = '0;
    endcase
  end

  // Flow control: advance the held request when the output register frees up
  assign adv      = s1_valid_r && (!out_valid_r || !out_stall);
  assign in_stall = s1_valid_r && out_valid_r && out_stall;
  assign in_acc   = in_valid && !in_stall;

  // Input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_acc) begin
      s1_valid_r <= 1'b1;
    end else if (adv) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_data_r <= in_data;
    end
  end

  fbpa_core #(
    .POOLS         (POOLS),
    .SLOTS         (SLOTS),
    .MAX_SIZE_LOG2 (MAX_SIZE_LOG2)
  ) u_core (
    .cfg      (cfg_r),
    .req      (s1_data_r),
    .used     (used_r),
    .used_nxt (used_nxt),
    .result   (result)
  );

  // Used bits: commit on advance
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      used_r <= '0;
    end else if (adv) begin
      used_r <= used_nxt;
    end
  end

  // Output register: hold while stalled
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= adv || (out_valid_r && out_stall);
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_data_r <= result;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

### hdl/fbpa_checker.sv
// ----------------------------------------------------------------------------
// fbpa_checker
// Port-level checks for the fixed block pool allocator, bound to the top level.
// ----------------------------------------------------------------------------
module fbpa_checker import fbpa_pkg::*; (
  input logic      clk,
  input logic      rst_n,
  input logic      in_stall,
  input logic      out_valid,
  input logic      out_stall,
  input fbpa_out_t out_data
);

  // Hold a stalled result
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled result changed or dropped");

  // Drop every result during reset
  a_reset_clear: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid straight after reset");

  // Stall requests only behind a stalled, full output
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid && out_stall)
    else $error("request stalled without output back-pressure");

  // Carry a block address only with a grant
  a_addr_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.status != STATUS_GRANTED |-> out_data.block_address == '0)
    else $error("non-zero address on a result without a grant");

endmodule

bind fixed_block_pool_allocator_core fbpa_checker u_fbpa_checker (.*);

### tb/sv/fixed_block_pool_allocator_core_tb.sv
// ----------------------------------------------------------------------------
// fixed_block_pool_allocator_core_tb
// Self-checking bench for the fixed block pool allocator. Pool geometry is
// programmed over APB between phases, while the allocator is idle. Allocate
// and free requests are driven on the request channel with random gaps and
// random result stalls. A scoreboard keeps its own used bits and geometry,
// predicts each result as its request is accepted, and compares every
// result field by field, in order.
// ----------------------------------------------------------------------------
module fixed_block_pool_allocator_core_tb;
  import fbpa_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int SLOT_COUNT     = 32;
  localparam int MAX_LOG2       = 12;
  localparam int MAX_REQ_SIZE   = 4096;
  localparam int LATENCY        = 2;
  localparam int PHASES         = 8;
  localparam int CALM_PHASE     = 3;
  localparam int IDLE_PERCENT   = 17;
  localparam int WATCHDOG_LIMIT = 2000;

  // --------------------------------------------------------------------------
  // Allocator scoreboard: geometry, used bits and outstanding results
  // --------------------------------------------------------------------------
  class alloc_scoreboard;
    logic [LOG2_W-1:0]     size_log2   [REG_POOLS];
    logic [COUNT_W-1:0]    block_count [REG_POOLS];
    logic [SLOT_COUNT-1:0] used_bits   [REG_POOLS];
    fbpa_out_t             expected_q  [$];
    logic [ADDR_W-1:0]     granted_q   [$];
    int                    errors;

    function new();
      for (int p = 0; p < REG_POOLS; p++) begin
        size_log2[p]   = '0;
        block_count[p] = '0;
        used_bits[p]   = '0;
      end
      size_log2[0]   = POOL0_LOG2_RST;
      block_count[0] = POOL0_COUNT_RST;
      errors         = 0;
    endfunction

    // Odd indexes hold block counts, even ones block size log2
    function void set_reg(reg_idx_t idx, logic [APB_DATA_W-1:0] value);
      if (idx[0]) block_count[idx[2:1]] = value[COUNT_W-1:0];
      else size_log2[idx[2:1]] = value[LOG2_W-1:0];
    endfunction

    // Clamp oversized fields
    function int unsigned eff_log2(int p);
      return (size_log2[p] > MAX_LOG2) ? MAX_LOG2 : size_log2[p];
    endfunction

    function int unsigned eff_count(int p);
      return (block_count[p] > SLOT_COUNT) ? SLOT_COUNT : block_count[p];
    endfunction

    function int pending();
      return expected_q.size();
    endfunction

    // Work out the result of an accepted request and update the used bits
    function void note_request(fbpa_in_t req);
      fbpa_out_t             res;
      int unsigned           lg;
      int unsigned           cnt;
      int unsigned           slot;
      logic [ADDR_W-1:0]     base;
      logic [ADDR_W-1:0]     off;
      logic [63:0]           span;
      logic [SLOT_COUNT-1:0] free_bits;
      bit                    done;
      res  = '0;
      base = '0;
      done = 1'b0;
      if (req.operation == OP_ALLOC) begin
        res.status = STATUS_NO_BLOCK;
        for (int p = 0; p < REG_POOLS; p++) begin
          lg        = eff_log2(p);
          cnt       = eff_count(p);
          span      = (64'd1 << cnt) - 64'd1;
          free_bits = ~used_bits[p] & span[SLOT_COUNT-1:0];
          // First pool that is big enough and not full wins
          if (!done && (32'd1 << lg) >= req.request_size && free_bits != '0) begin
            slot = 0;
            while (!free_bits[slot]) slot++;
            used_bits[p][slot] = 1'b1;
            res.status         = STATUS_GRANTED;
            res.block_address  = base + ADDR_W'(slot << lg);
            granted_q.insert(granted_q.size(), res.block_address);
            done = 1'b1;
          end
          base = base + ADDR_W'(cnt << lg);
        end
      end else begin
        for (int p = 0; p < REG_POOLS; p++) begin
          lg   = eff_log2(p);
          cnt  = eff_count(p);
          off  = req.release_address - base;
          slot = off >> lg;
          // Only an exact block start inside the pool counts
          if ((off & ((20'd1 << lg) - 20'd1)) == 20'd0 && slot < cnt) begin
            used_bits[p][slot] = 1'b0;
            done = 1'b1;
          end
          base = base + ADDR_W'(cnt << lg);
        end
        res.status = done ? STATUS_FREED : STATUS_NOT_FOUND;
        for (int k = granted_q.size() - 1; k >= 0; k--) begin
          if (granted_q[k] == req.release_address) granted_q.delete(k);
        end
      end
      expected_q.insert(expected_q.size(), res);
    endfunction

    // Compare a result with the oldest prediction
    function void check_result(fbpa_out_t got);
      fbpa_out_t want;
      if (expected_q.size() == 0) begin
        $error("unexpected result: status %0d block_address 0x%05h",
               got.status, got.block_address);
        errors++;
        return;
      end
      want = expected_q.pop_front();
      if (got.status !== want.status) begin
        $error("status: expected %0d, got %0d", want.status, got.status);
        errors++;
      end
      if (got.block_address !== want.block_address) begin
        $error("block_address: expected 0x%05h, got 0x%05h",
               want.block_address, got.block_address);
        errors++;
      end
    endfunction
  endclass

  // --------------------------------------------------------------------------
  // Signals and block under test
  // --------------------------------------------------------------------------
  logic                  clk;
  logic                  rst_n;
  logic                  in_valid;
  logic                  in_stall;
  fbpa_in_t              in_data;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  fbpa_out_t             out_data;
  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic [APB_ADDR_W-1:0] paddr;
  logic [APB_DATA_W-1:0] pwdata;
  logic [APB_DATA_W-1:0] prdata;
  logic                  pready;

  alloc_scoreboard       sb;
  bit                    calm;
  logic [ADDR_W-1:0]     last_freed;
  int                    idle_cycles;

  logic [REG_POOLS-1:0][LOG2_W-1:0]  phase_log2  [PHASES];
  logic [REG_POOLS-1:0][COUNT_W-1:0] phase_count [PHASES];
  int phase_items [PHASES] = '{240, 200, 60, 200, 200, 200, 200, 240};

  fixed_block_pool_allocator_core dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready)
  );

  // 10 ns clock
  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // Stall the result channel at random, except in the calm phase
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      out_stall <= !calm && ($urandom_range(0, 99) < IDLE_PERCENT);
    end
  end

  // Check every accepted result
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) sb.check_result(out_data);
  end

  // Abort when nothing moves for too long
  initial begin
    idle_cycles = 0;
    while (idle_cycles < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((in_valid && !in_stall) || (out_valid && !out_stall) || (psel && penable)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
    end
    $display("RESULT: ERROR");
    $finish;
  end

  // --------------------------------------------------------------------------
  // Driving tasks
  // --------------------------------------------------------------------------
  // Write one pool register: setup cycle, then access cycle
  task automatic write_reg(input reg_idx_t idx, input logic [APB_DATA_W-1:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    sb.set_reg(idx, value);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
  endtask

  task automatic apply_geometry(input logic [REG_POOLS-1:0][LOG2_W-1:0]  lg,
                                input logic [REG_POOLS-1:0][COUNT_W-1:0] cnt);
    write_reg(REG_POOL0_SIZE_LOG2,   APB_DATA_W'(lg[0]));
    write_reg(REG_POOL0_BLOCK_COUNT, APB_DATA_W'(cnt[0]));
    write_reg(REG_POOL1_SIZE_LOG2,   APB_DATA_W'(lg[1]));
    write_reg(REG_POOL1_BLOCK_COUNT, APB_DATA_W'(cnt[1]));
    write_reg(REG_POOL2_SIZE_LOG2,   APB_DATA_W'(lg[2]));
    write_reg(REG_POOL2_BLOCK_COUNT, APB_DATA_W'(cnt[2]));
    write_reg(REG_POOL3_SIZE_LOG2,   APB_DATA_W'(lg[3]));
    write_reg(REG_POOL3_BLOCK_COUNT, APB_DATA_W'(cnt[3]));
  endtask

  // Present one request, hold it while stalled, note it on acceptance
  task automatic send_request(input fbpa_in_t req);
    while (!calm && $urandom_range(0, 99) < IDLE_PERCENT) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= req;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.note_request(req);
  endtask

  // Stop sending and wait until every predicted result has come back
  task automatic drain_results();
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (LATENCY + 1) @(posedge clk);
  endtask

  function automatic fbpa_in_t pack_request(op_t op, int unsigned size, int unsigned addr);
    fbpa_in_t r;
    r.operation       = op;
    r.request_size    = REQ_W'(size);
    r.release_address = ADDR_W'(addr);
    return r;
  endfunction

  // Mostly sized allocates and frees of granted blocks, plus some noise
  function automatic fbpa_in_t make_request();
    fbpa_in_t    r;
    int unsigned kind;
    int unsigned p;
    r.operation       = OP_ALLOC;
    r.request_size    = REQ_W'($urandom_range(0, MAX_REQ_SIZE));
    r.release_address = ADDR_W'($urandom);
    kind = $urandom_range(0, 99);
    if (kind < 80) begin
      if (sb.granted_q.size() != 0 && $urandom_range(0, 1) == 1) begin
        r.operation       = OP_FREE;
        r.release_address = sb.granted_q[$urandom_range(0, sb.granted_q.size() - 1)];
        last_freed        = r.release_address;
      end else begin
        p = $urandom_range(0, REG_POOLS - 1);
        r.request_size = REQ_W'($urandom_range(0, 1 << sb.eff_log2(p)));
      end
    end else if (kind < 88) begin
      // free the same block twice
      r.operation       = OP_FREE;
      r.release_address = last_freed;
    end else if (kind < 94 && sb.granted_q.size() != 0) begin
      // misaligned free just past a block start
      r.operation       = OP_FREE;
      r.release_address = sb.granted_q[$urandom_range(0, sb.granted_q.size() - 1)]
                          + ADDR_W'($urandom_range(1, 3));
    end else begin
      r.operation = op_t'($urandom_range(0, 1));
    end
    return r;
  endfunction

  // --------------------------------------------------------------------------
  // Stimulus
  // --------------------------------------------------------------------------
  initial begin
    in_valid   <= 1'b0;
    in_data    <= '0;
    psel       <= 1'b0;
    penable    <= 1'b0;
    pwrite     <= 1'b0;
    paddr      <= '0;
    pwdata     <= '0;
    rst_n      <= 1'b0;
    calm       = 1'b0;
    last_freed = '0;
    sb         = new();

    // Geometry per phase, listed pool 3 down to pool 0
    phase_log2[0]  = {4'd8, 4'd5, 4'd3, 4'd2};
    phase_count[0] = {6'd2, 6'd4, 6'd8, 6'd8};
    phase_log2[1]  = {4'd12, 4'd14, 4'd13, 4'd15};
    phase_count[1] = {6'd40, 6'd32, 6'd33, 6'd63};
    phase_log2[2]  = '0;
    phase_count[2] = '0;
    phase_log2[3]  = {4'd0, 4'd6, 4'd1, 4'd4};
    phase_count[3] = {6'd5, 6'd3, 6'd32, 6'd1};
    phase_log2[4]  = {4'd3, 4'd2, 4'd1, 4'd0};
    phase_count[4] = {6'd32, 6'd32, 6'd32, 6'd32};
    for (int ph = 5; ph < 7; ph++) begin
      for (int p = 0; p < REG_POOLS; p++) begin
        phase_log2[ph][p]  = LOG2_W'($urandom_range(0, 15));
        phase_count[ph][p] = COUNT_W'($urandom_range(0, 63));
      end
    end
    phase_log2[7]  = {4'd12, 4'd12, 4'd12, 4'd12};
    phase_count[7] = {6'd32, 6'd32, 6'd32, 6'd32};

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset geometry: one pool of 32 four-byte blocks
    send_request(pack_request(OP_ALLOC, 4, 0));
    send_request(pack_request(OP_ALLOC, 5, 0));
    send_request(pack_request(OP_FREE, 0, 0));

    // Tiny pool, single big block, clamped size and count, empty last pool
    drain_results();
    apply_geometry({4'd3, 4'd15, 4'd12, 4'd0}, {6'd0, 6'd40, 6'd1, 6'd2});
    send_request(pack_request(OP_ALLOC, 0, 0));
    send_request(pack_request(OP_ALLOC, 1, 0));
    send_request(pack_request(OP_ALLOC, 1, 0));
    send_request(pack_request(OP_ALLOC, MAX_REQ_SIZE, 0));
    send_request(pack_request(OP_ALLOC, MAX_REQ_SIZE, 20'hFFFFF));
    send_request(pack_request(OP_ALLOC, 2, 0));
    send_request(pack_request(OP_FREE, MAX_REQ_SIZE, 0));
    send_request(pack_request(OP_FREE, 0, 0));
    send_request(pack_request(OP_FREE, 0, 1));
    send_request(pack_request(OP_FREE, 0, 3));
    send_request(pack_request(OP_FREE, 0, 4099));
    send_request(pack_request(OP_FREE, 0, 135170));
    send_request(pack_request(OP_FREE, 0, 20'hFFFFF));
    send_request(pack_request(OP_FREE, MAX_REQ_SIZE, 2));
    send_request(pack_request(OP_ALLOC, 4095, 0));
    send_request(pack_request(OP_ALLOC, MAX_REQ_SIZE, 0));

    // Random phases; used bits carry over each geometry change
    for (int ph = 0; ph < PHASES; ph++) begin
      drain_results();
      apply_geometry(phase_log2[ph], phase_count[ph]);
      calm = (ph == CALM_PHASE);
      for (int n = 0; n < phase_items[ph]; n++) begin
        if (ph == CALM_PHASE && n == phase_items[ph] / 2) drain_results();
        send_request(make_request());
      end
    end
    drain_results();
    repeat (LATENCY + 4) @(posedge clk);

    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

### fixed_block_pool_allocator_core.f
hdl/fbpa_pkg.sv
hdl/fbpa_core.sv
hdl/fixed_block_pool_allocator_core.sv
hdl/fbpa_checker.sv
tb/sv/fixed_block_pool_allocator_core_tb.sv
